>>> rtl/elliptical_gaussian_sample_defines.svh
// assertion macros for the elliptical gaussian sample block
// used by the top level, needs nothing else
`ifndef ELLIPTICAL_GAUSSIAN_SAMPLE_DEFINES_SVH
`define ELLIPTICAL_GAUSSIAN_SAMPLE_DEFINES_SVH

// same-cycle implication
`define EGS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EGS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/egs_pkg.sv
// shared widths, constants, tables and stage map of the gaussian sample pipeline
// no dependencies
`default_nettype none

package egs_pkg;

  localparam int OFS_W = 16;
  localparam int AMP_W = 32;
  localparam int WID_W = 16;
  localparam int ANG_W = 16;
  localparam int VAL_W = 32;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 19;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 19'sd39797;

  // rotation
  localparam int PROD_W = 35;
  localparam int SUM_W  = 36;
  localparam int MAG_W  = 34;

  // restoring divider cells, shared by scaling and normalization
  localparam int DIV_REM_W = 65;
  localparam int DIV_DEN_W = 51;
  localparam int DIV_Q_W   = 32;
  localparam int STEP_W    = 5;

  // scaling
  localparam int SCL_BITS = 20;
  localparam logic [SCL_BITS-1:0] SCL_CLAMP = 20'd786432;

  // exponent
  localparam int SQ_W = 40;
  localparam int E_W  = 40;
  localparam int TE_W = 57;
  localparam int T_W  = 26;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [TE_W:0] T_ROUND = 58'h0_0000_8000_0000;

  // exponential
  localparam int FRAC_BITS = 16;
  localparam int EXP_STEPS = 16;
  localparam int P_W       = 25;
  localparam int TBL_W     = 24;
  localparam int MUL_W     = P_W + TBL_W;
  localparam logic [P_W-1:0]   P_ONE     = 25'h100_0000;
  localparam logic [MUL_W-1:0] EXP_ROUND = 49'h0_0000_0080_0000;
  localparam int EXP_K_MAX = 25;

  // normalization
  localparam int N0_W = 57;
  localparam int WM_W = 32;
  localparam int D_W  = 51;
  localparam int N_W  = 65;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  // stage map, each index is one register stage
  localparam int ST_CORDIC  = 0;
  localparam int ST_ROT_MUL = ST_CORDIC + CORDIC_STEPS;
  localparam int ST_ROT_SUM = ST_ROT_MUL + 1;
  localparam int ST_SCL_CHK = ST_ROT_SUM + 1;
  localparam int ST_SCL_DIV = ST_SCL_CHK + 1;
  localparam int ST_SQ      = ST_SCL_DIV + SCL_BITS;
  localparam int ST_E       = ST_SQ + 1;
  localparam int ST_TE      = ST_E + 1;
  localparam int ST_T       = ST_TE + 1;
  localparam int ST_EXP     = ST_T + 1;
  localparam int ST_G       = ST_EXP + EXP_STEPS;
  localparam int ST_NMUL    = ST_G + 1;
  localparam int ST_DMUL    = ST_NMUL + 1;
  localparam int ST_QCHK    = ST_DMUL + 1;
  localparam int ST_QDIV    = ST_QCHK + 1;
  localparam int NST        = ST_QDIV + DIV_Q_W;

  // per-transaction data that rides beside the datapath
  typedef struct packed {
    logic [AMP_W-1:0]        amp;
    logic [WID_W-1:0]        maj;
    logic [WID_W-1:0]        mnr;
    logic                    bad;
    logic                    flip;
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    logic                    ovf_x;
    logic                    ovf_y;
    logic                    ovf_q;
  } side_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [3:0] idx);
    logic signed [CORDIC_W-1:0] r;
    unique case (idx)
      4'd0:  r = 19'sd51472;
      4'd1:  r = 19'sd30386;
      4'd2:  r = 19'sd16055;
      4'd3:  r = 19'sd8150;
      4'd4:  r = 19'sd4091;
      4'd5:  r = 19'sd2047;
      4'd6:  r = 19'sd1024;
      4'd7:  r = 19'sd512;
      4'd8:  r = 19'sd256;
      4'd9:  r = 19'sd128;
      4'd10: r = 19'sd64;
      4'd11: r = 19'sd32;
      4'd12: r = 19'sd16;
      4'd13: r = 19'sd8;
      4'd14: r = 19'sd4;
      4'd15: r = 19'sd2;
    endcase
    return r;
  endfunction

  // 2^(-2^-(idx+1)) in q24
  function automatic logic [TBL_W-1:0] pow2_frac_q24(input logic [3:0] idx);
    logic [TBL_W-1:0] r;
    unique case (idx)
      4'd0:  r = 24'd11863283;
      4'd1:  r = 24'd14107901;
      4'd2:  r = 24'd15384775;
      4'd3:  r = 24'd16065917;
      4'd4:  r = 24'd16417715;
      4'd5:  r = 24'd16596492;
      4'd6:  r = 24'd16686610;
      4'd7:  r = 24'd16731851;
      4'd8:  r = 24'd16754518;
      4'd9:  r = 24'd16765863;
      4'd10: r = 24'd16771539;
      4'd11: r = 24'd16774377;
      4'd12: r = 24'd16775797;
      4'd13: r = 24'd16776506;
      4'd14: r = 24'd16776861;
      4'd15: r = 24'd16777039;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/egs_in_if.sv
// input channel of the gaussian sample block: valid, ready and sample parameters
// depends on egs_pkg
`default_nettype none

interface egs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [egs_pkg::OFS_W-1:0] dx;
  logic signed [egs_pkg::OFS_W-1:0] dy;
  logic [egs_pkg::AMP_W-1:0]        amplitude;
  logic [egs_pkg::WID_W-1:0]        major_width;
  logic [egs_pkg::WID_W-1:0]        minor_width;
  logic signed [egs_pkg::ANG_W-1:0] angle;

  modport source (output valid, dx, dy, amplitude, major_width, minor_width, angle,
                  input ready);
  modport sink (input valid, dx, dy, amplitude, major_width, minor_width, angle,
                output ready);
endinterface

`default_nettype wire

>>> rtl/egs_out_if.sv
// output channel of the gaussian sample block: valid, ready and result
// depends on egs_pkg
`default_nettype none

interface egs_out_if;
  logic                      valid;
  logic                      ready;
  logic [egs_pkg::VAL_W-1:0] sample_value;
  logic                      bad_width;

  modport source (output valid, sample_value, bad_width, input ready);
  modport sink (input valid, sample_value, bad_width, output ready);
endinterface

`default_nettype wire

>>> rtl/egs_cordic_cell.sv
// one rotation step of the sine/cosine cordic chain
// depends on egs_pkg
`default_nettype none

module egs_cordic_cell (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [3:0]                           idx,
  input  logic signed [egs_pkg::CORDIC_W-1:0]  x_in,
  input  logic signed [egs_pkg::CORDIC_W-1:0]  y_in,
  input  logic signed [egs_pkg::CORDIC_W-1:0]  z_in,
  output logic signed [egs_pkg::CORDIC_W-1:0]  x_out,
  output logic signed [egs_pkg::CORDIC_W-1:0]  y_out,
  output logic signed [egs_pkg::CORDIC_W-1:0]  z_out
);

  logic signed [egs_pkg::CORDIC_W-1:0] xs, ys, x_next, y_next, z_next, ang;

  always_comb begin
    xs  = x_in >>> idx;
    ys  = y_in >>> idx;
    ang = egs_pkg::atan_q16(idx);
    if (!z_in[egs_pkg::CORDIC_W-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ang;
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/egs_div_cell.sv
// one quotient bit of a pipelined restoring divider
// depends on egs_pkg
`default_nettype none

module egs_div_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [egs_pkg::STEP_W-1:0]        step,
  input  logic [egs_pkg::DIV_REM_W-1:0]     rem_in,
  input  logic [egs_pkg::DIV_DEN_W-1:0]     den_in,
  input  logic [egs_pkg::DIV_Q_W-1:0]       q_in,
  output logic [egs_pkg::DIV_REM_W-1:0]     rem_out,
  output logic [egs_pkg::DIV_DEN_W-1:0]     den_out,
  output logic [egs_pkg::DIV_Q_W-1:0]       q_out
);

  logic [egs_pkg::DIV_REM_W-1:0] den_ext, rem_next;
  logic                          fit;

  always_comb begin
    den_ext  = {{(egs_pkg::DIV_REM_W-egs_pkg::DIV_DEN_W){1'b0}}, den_in};
    // floor(rem / 2^step) >= den is the same test as rem >= den * 2^step
    fit      = (rem_in >> step) >= den_ext;
    rem_next = fit ? rem_in - (den_ext << step) : rem_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      den_out <= den_in;
      q_out   <= {q_in[egs_pkg::DIV_Q_W-2:0], fit};
    end
  end

endmodule

`default_nettype wire

>>> rtl/egs_exp_cell.sv
// one fraction bit of the 2^-t product chain
// depends on egs_pkg
`default_nettype none

module egs_exp_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [3:0]                  idx,
  input  logic [egs_pkg::P_W-1:0]     p_in,
  input  logic [egs_pkg::T_W-1:0]     t_in,
  output logic [egs_pkg::P_W-1:0]     p_out,
  output logic [egs_pkg::T_W-1:0]     t_out
);

  logic [egs_pkg::FRAC_BITS-1:0] frac;
  logic [egs_pkg::MUL_W-1:0]     prod;
  logic [egs_pkg::P_W-1:0]       p_next;

  always_comb begin
    frac   = t_in[egs_pkg::FRAC_BITS-1:0];
    prod   = {{(egs_pkg::MUL_W-egs_pkg::P_W){1'b0}}, p_in} *
             {{(egs_pkg::MUL_W-egs_pkg::TBL_W){1'b0}}, egs_pkg::pow2_frac_q24(idx)} +
             egs_pkg::EXP_ROUND;
    // cell idx handles fraction bit 15 - idx, which is ~idx on four bits
    p_next = frac[~idx] ? prod[egs_pkg::TBL_W +: egs_pkg::P_W] : p_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= p_next;
      t_out <= t_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/elliptical_gaussian_sample.sv
// throughput: one transaction per cycle while the output is not stalled, set by the
//   fully pipelined cell chains
//   (16 cordic cells, 2x20 scaling divider cells, 16 exponential cells, 32 divider cells)
// a stalled output freezes the pipeline only while its last stage holds a result
// reset clears all valid bits, the output valid among them; no data is cleared
`default_nettype none
`include "elliptical_gaussian_sample_defines.svh"

module elliptical_gaussian_sample (
  input logic        clk,
  input logic        rst,
  egs_in_if.sink     sample_in,
  egs_out_if.source  sample_out
);

  localparam int NST = egs_pkg::NST;

  logic                  en;
  logic [NST-1:0]        vld;
  egs_pkg::side_t        side_in;
  egs_pkg::side_t        side_scl, side_qchk;
  egs_pkg::side_t        side [NST];

  logic signed [egs_pkg::ANG_W-1:0]     ang_f;
  logic                                 flip_in;
  logic signed [egs_pkg::CORDIC_W-1:0]  z0;
  logic signed [egs_pkg::CORDIC_W-1:0]  cx [egs_pkg::CORDIC_STEPS+1];
  logic signed [egs_pkg::CORDIC_W-1:0]  cy [egs_pkg::CORDIC_STEPS+1];
  logic signed [egs_pkg::CORDIC_W-1:0]  cz [egs_pkg::CORDIC_STEPS+1];

  logic signed [egs_pkg::CORDIC_W-1:0]  c_val, s_val;
  logic signed [egs_pkg::PROD_W-1:0]    dx_w, dy_w, c_w, s_w;
  logic signed [egs_pkg::PROD_W-1:0]    p_xc, p_ys, p_yc, p_xs;
  logic signed [egs_pkg::SUM_W-1:0]     xt, yt, xt_abs, yt_abs;
  logic [egs_pkg::MAG_W-1:0]            mx, my, sx_mag, sy_mag;

  logic [egs_pkg::DIV_REM_W-1:0] sxr [egs_pkg::SCL_BITS+1];
  logic [egs_pkg::DIV_DEN_W-1:0] sxd [egs_pkg::SCL_BITS+1];
  logic [egs_pkg::DIV_Q_W-1:0]   sxq [egs_pkg::SCL_BITS+1];
  logic [egs_pkg::DIV_REM_W-1:0] syr [egs_pkg::SCL_BITS+1];
  logic [egs_pkg::DIV_DEN_W-1:0] syd [egs_pkg::SCL_BITS+1];
  logic [egs_pkg::DIV_Q_W-1:0]   syq [egs_pkg::SCL_BITS+1];

  logic [egs_pkg::SCL_BITS-1:0] qx, qy, u, v;
  logic [egs_pkg::SQ_W-1:0]     uu, vv;
  logic [egs_pkg::SQ_W:0]       e_sum;
  logic [egs_pkg::E_W-1:0]      e;
  logic [egs_pkg::TE_W-1:0]     te;
  logic [egs_pkg::TE_W:0]       t_sum;
  logic [egs_pkg::T_W-1:0]      t;

  logic [egs_pkg::P_W-1:0] ep [egs_pkg::EXP_STEPS+1];
  logic [egs_pkg::T_W-1:0] et [egs_pkg::EXP_STEPS+1];

  logic [egs_pkg::T_W-egs_pkg::FRAC_BITS-1:0] k;
  logic [egs_pkg::P_W-1:0]   g_next, g;
  logic [egs_pkg::N0_W-1:0]  n0;
  logic [egs_pkg::WM_W-1:0]  wm;
  logic [egs_pkg::D_W-1:0]   d, qd;
  logic [egs_pkg::N_W-1:0]   n, qn;

  logic [egs_pkg::DIV_REM_W-1:0] qr  [egs_pkg::DIV_Q_W+1];
  logic [egs_pkg::DIV_DEN_W-1:0] qdd [egs_pkg::DIV_Q_W+1];
  logic [egs_pkg::DIV_Q_W-1:0]   qq  [egs_pkg::DIV_Q_W+1];

  logic                      out_valid;
  logic [egs_pkg::VAL_W-1:0] out_value;
  logic                      out_bad;

  // pipeline holds only when a finished result would be overwritten
  assign en              = !(vld[NST-1] && out_valid && !sample_out.ready);
  assign sample_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], sample_in.valid};
    end
  end

  // fold the angle into plus or minus pi/2
  always_comb begin
    flip_in = 1'b0;
    ang_f   = sample_in.angle;
    if (sample_in.angle > egs_pkg::HALF_PI_Q13) begin
      ang_f   = sample_in.angle - egs_pkg::PI_Q13;
      flip_in = 1'b1;
    end else if (sample_in.angle < -egs_pkg::HALF_PI_Q13) begin
      ang_f   = sample_in.angle + egs_pkg::PI_Q13;
      flip_in = 1'b1;
    end
    z0 = {{(egs_pkg::CORDIC_W-egs_pkg::ANG_W){ang_f[egs_pkg::ANG_W-1]}}, ang_f} << 3;

    side_in       = '0;
    side_in.amp   = sample_in.amplitude;
    side_in.maj   = sample_in.major_width;
    side_in.mnr   = sample_in.minor_width;
    side_in.bad   = (sample_in.major_width == '0) || (sample_in.minor_width == '0);
    side_in.flip  = flip_in;
    side_in.dx    = sample_in.dx;
    side_in.dy    = sample_in.dy;
  end

  assign cx[0] = egs_pkg::CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z0;

  for (genvar i = 0; i < egs_pkg::CORDIC_STEPS; i++) begin : g_cordic
    egs_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (4'(i)),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
  end

  // rotation products and sums
  always_comb begin
    c_val  = side[egs_pkg::ST_ROT_MUL-1].flip ? -cx[egs_pkg::CORDIC_STEPS]
                                              :  cx[egs_pkg::CORDIC_STEPS];
    s_val  = side[egs_pkg::ST_ROT_MUL-1].flip ? -cy[egs_pkg::CORDIC_STEPS]
                                              :  cy[egs_pkg::CORDIC_STEPS];
    dx_w   = $signed({{(egs_pkg::PROD_W-egs_pkg::OFS_W){side[egs_pkg::ST_ROT_MUL-1].dx[egs_pkg::OFS_W-1]}},
                      side[egs_pkg::ST_ROT_MUL-1].dx});
    dy_w   = $signed({{(egs_pkg::PROD_W-egs_pkg::OFS_W){side[egs_pkg::ST_ROT_MUL-1].dy[egs_pkg::OFS_W-1]}},
                      side[egs_pkg::ST_ROT_MUL-1].dy});
    c_w    = $signed({{(egs_pkg::PROD_W-egs_pkg::CORDIC_W){c_val[egs_pkg::CORDIC_W-1]}}, c_val});
    s_w    = $signed({{(egs_pkg::PROD_W-egs_pkg::CORDIC_W){s_val[egs_pkg::CORDIC_W-1]}}, s_val});
    xt     = {p_xc[egs_pkg::PROD_W-1], p_xc} + {p_ys[egs_pkg::PROD_W-1], p_ys};
    yt     = {p_yc[egs_pkg::PROD_W-1], p_yc} - {p_xs[egs_pkg::PROD_W-1], p_xs};
    xt_abs = xt[egs_pkg::SUM_W-1] ? -xt : xt;
    yt_abs = yt[egs_pkg::SUM_W-1] ? -yt : yt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc   <= dx_w * c_w;
      p_ys   <= dy_w * s_w;
      p_yc   <= dy_w * c_w;
      p_xs   <= dx_w * s_w;
      mx     <= xt_abs[egs_pkg::MAG_W-1:0];
      my     <= yt_abs[egs_pkg::MAG_W-1:0];
      sx_mag <= mx;
      sy_mag <= my;
    end
  end

  assign sxr[0] = {{(egs_pkg::DIV_REM_W-egs_pkg::MAG_W){1'b0}}, sx_mag};
  assign sxd[0] = {{(egs_pkg::DIV_DEN_W-egs_pkg::WID_W){1'b0}},
                   side[egs_pkg::ST_SCL_CHK].maj};
  assign sxq[0] = '0;
  assign syr[0] = {{(egs_pkg::DIV_REM_W-egs_pkg::MAG_W){1'b0}}, sy_mag};
  assign syd[0] = {{(egs_pkg::DIV_DEN_W-egs_pkg::WID_W){1'b0}},
                   side[egs_pkg::ST_SCL_CHK].mnr};
  assign syq[0] = '0;

  for (genvar i = 0; i < egs_pkg::SCL_BITS; i++) begin : g_scale
    egs_div_cell u_xcell (
      .clk     (clk),
      .en      (en),
      .step    (5'(egs_pkg::SCL_BITS-1-i)),
      .rem_in  (sxr[i]),
      .den_in  (sxd[i]),
      .q_in    (sxq[i]),
      .rem_out (sxr[i+1]),
      .den_out (sxd[i+1]),
      .q_out   (sxq[i+1])
    );
    egs_div_cell u_ycell (
      .clk     (clk),
      .en      (en),
      .step    (5'(egs_pkg::SCL_BITS-1-i)),
      .rem_in  (syr[i]),
      .den_in  (syd[i]),
      .q_in    (syq[i]),
      .rem_out (syr[i+1]),
      .den_out (syd[i+1]),
      .q_out   (syq[i+1])
    );
  end

  // clamp, squares, exponent
  always_comb begin
    qx = sxq[egs_pkg::SCL_BITS][egs_pkg::SCL_BITS-1:0];
    qy = syq[egs_pkg::SCL_BITS][egs_pkg::SCL_BITS-1:0];
    u  = (side[egs_pkg::ST_SQ-1].ovf_x || qx > egs_pkg::SCL_CLAMP) ? egs_pkg::SCL_CLAMP : qx;
    v  = (side[egs_pkg::ST_SQ-1].ovf_y || qy > egs_pkg::SCL_CLAMP) ? egs_pkg::SCL_CLAMP : qy;
    e_sum = {1'b0, uu} + {1'b0, vv};
    t_sum = {1'b0, te} + egs_pkg::T_ROUND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu <= {{(egs_pkg::SQ_W-egs_pkg::SCL_BITS){1'b0}}, u} *
            {{(egs_pkg::SQ_W-egs_pkg::SCL_BITS){1'b0}}, u};
      vv <= {{(egs_pkg::SQ_W-egs_pkg::SCL_BITS){1'b0}}, v} *
            {{(egs_pkg::SQ_W-egs_pkg::SCL_BITS){1'b0}}, v};
      e  <= e_sum[egs_pkg::SQ_W:1];
      te <= {{(egs_pkg::TE_W-egs_pkg::E_W){1'b0}}, e} *
            {{(egs_pkg::TE_W-$bits(egs_pkg::LOG2E_Q16)){1'b0}}, egs_pkg::LOG2E_Q16};
      t  <= t_sum[32 +: egs_pkg::T_W];
    end
  end

  assign ep[0] = egs_pkg::P_ONE;
  assign et[0] = t;

  for (genvar i = 0; i < egs_pkg::EXP_STEPS; i++) begin : g_exp
    egs_exp_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (4'(i)),
      .p_in  (ep[i]),
      .t_in  (et[i]),
      .p_out (ep[i+1]),
      .t_out (et[i+1])
    );
  end

  // integer part of t shifts, normalization products
  always_comb begin
    k      = et[egs_pkg::EXP_STEPS][egs_pkg::T_W-1:egs_pkg::FRAC_BITS];
    g_next = (k >= egs_pkg::EXP_K_MAX) ? '0 : ep[egs_pkg::EXP_STEPS] >> k;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g  <= g_next;
      n0 <= {{(egs_pkg::N0_W-egs_pkg::AMP_W){1'b0}}, side[egs_pkg::ST_NMUL-1].amp} *
            {{(egs_pkg::N0_W-egs_pkg::P_W){1'b0}}, g};
      wm <= {{(egs_pkg::WM_W-egs_pkg::WID_W){1'b0}}, side[egs_pkg::ST_NMUL-1].maj} *
            {{(egs_pkg::WM_W-egs_pkg::WID_W){1'b0}}, side[egs_pkg::ST_NMUL-1].mnr};
      d  <= {{(egs_pkg::D_W-egs_pkg::WM_W){1'b0}}, wm} *
            {{(egs_pkg::D_W-$bits(egs_pkg::TWO_PI_Q16)){1'b0}}, egs_pkg::TWO_PI_Q16};
      n  <= {n0, 8'b0};
      qn <= n;
      qd <= d;
    end
  end

  // scaling quotient >= 2^20 goes to the clamp, normalization quotient >= 2^32 to all ones
  always_comb begin
    side_scl        = side[egs_pkg::ST_SCL_CHK-1];
    side_scl.ovf_x  = (mx >> egs_pkg::SCL_BITS) >= side[egs_pkg::ST_SCL_CHK-1].maj;
    side_scl.ovf_y  = (my >> egs_pkg::SCL_BITS) >= side[egs_pkg::ST_SCL_CHK-1].mnr;
    side_qchk       = side[egs_pkg::ST_QCHK-1];
    side_qchk.ovf_q = n[egs_pkg::N_W-1:32] >= d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < NST; i++) begin
        if (i == egs_pkg::ST_SCL_CHK) begin
          side[i] <= side_scl;
        end else if (i == egs_pkg::ST_QCHK) begin
          side[i] <= side_qchk;
        end else begin
          side[i] <= side[i-1];
        end
      end
    end
  end

  assign qr[0]  = qn;
  assign qdd[0] = qd;
  assign qq[0]  = '0;

  for (genvar i = 0; i < egs_pkg::DIV_Q_W; i++) begin : g_quot
    egs_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .step    (5'(egs_pkg::DIV_Q_W-1-i)),
      .rem_in  (qr[i]),
      .den_in  (qdd[i]),
      .q_in    (qq[i]),
      .rem_out (qr[i+1]),
      .den_out (qdd[i+1]),
      .q_out   (qq[i+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || sample_out.ready) begin
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || sample_out.ready) begin
      out_bad <= side[NST-1].bad;
      if (side[NST-1].bad) begin
        out_value <= '0;
      end else if (side[NST-1].ovf_q) begin
        out_value <= '1;
      end else begin
        out_value <= qq[egs_pkg::DIV_Q_W];
      end
    end
  end

  assign sample_out.valid        = out_valid;
  assign sample_out.sample_value = out_value;
  assign sample_out.bad_width    = out_bad;

  `EGS_ASSERT_NXT(a_accept_enters, clk, rst, sample_in.valid && sample_in.ready, vld[0], "accepted transaction missing from first stage")
  `EGS_ASSERT_IMP(a_bad_is_zero, clk, rst, sample_out.valid && sample_out.bad_width, sample_out.sample_value == '0, "bad width result not zero")
  `EGS_ASSERT_IMP(a_gauss_le_one, clk, rst, vld[egs_pkg::ST_G], g <= egs_pkg::P_ONE, "gaussian factor above one")
  `EGS_ASSERT_NXT(a_stall_holds, clk, rst, vld[NST-1] && out_valid && !sample_out.ready, vld[NST-1], "last stage lost during stall")

endmodule

`default_nettype wire
